// File: design/psc_pkg.sv
// psc_pkg: shared types, codes and helpers for the packed saturating counter store
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package psc_pkg;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 17;
    localparam int ORDER_BITS     = 3;
    localparam int MAX_INDEX_BITS = 16;
    localparam int MAX_BIT_BITS   = 6;
    localparam int VALUE_BITS     = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNTER_WIDTH_LOG2 = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNTER_COUNT      = 1'd1;

    typedef enum logic [1:0] {
        ACT_GET = 2'd0,
        ACT_SET = 2'd1,
        ACT_ADD = 2'd2,
        ACT_SUB = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY
    } back_state_t;

    // one classified request as it travels from front to back
    typedef struct packed {
        action_t                   action;
        logic                      oor;
        logic [ORDER_BITS-1:0]     order;
        logic [MAX_INDEX_BITS-1:0] word_index;
        logic [MAX_BIT_BITS-1:0]   bit_offset;
    } job_t;

    // all-ones value of a counter of 2^order bits
    function automatic logic [VALUE_BITS-1:0] counter_mask(input logic [ORDER_BITS-1:0] order);
        logic [VALUE_BITS-1:0] m;
        begin
            case (order)
                3'd0:    m = 32'h0000_0001;
                3'd1:    m = 32'h0000_0003;
                3'd2:    m = 32'h0000_000F;
                3'd3:    m = 32'h0000_00FF;
                3'd4:    m = 32'h0000_FFFF;
                default: m = 32'hFFFF_FFFF;
            endcase
            return m;
        end
    endfunction

endpackage

// File: design/psc_front.sv
// psc_front: configuration registers and request classification
// depends on psc_pkg; feeds psc_queue
`timescale 1ns / 1ps

module psc_front
    import psc_pkg::*;
#(
    parameter int WORD_BITS_LOG2 = 6,
    parameter int STORE_WORDS    = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                action,
    input  logic [15:0]               position,
    input  logic                      q_full,
    input  logic                      clearing,
    output logic                      push,
    output job_t                      push_job
);

    localparam int OFFSET_BITS = 16 + (1 << ORDER_BITS) - 3;
    localparam logic [ORDER_BITS-1:0] MAX_ORDER =
        (WORD_BITS_LOG2 < 5) ? ORDER_BITS'(WORD_BITS_LOG2) : ORDER_BITS'(5);
    localparam logic [OFFSET_BITS-1:0] STORE_LIMIT = OFFSET_BITS'(STORE_WORDS);

    logic [ORDER_BITS-1:0]    order_reg;
    logic [CFG_DATA_BITS-1:0] count_reg;
    logic [ORDER_BITS-1:0]    order_eff;
    logic [OFFSET_BITS-1:0]   offset;
    logic [OFFSET_BITS-1:0]   word_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= '0;
            count_reg <= CFG_DATA_BITS'(65536);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_COUNTER_WIDTH_LOG2: order_reg <= cfg_data[ORDER_BITS-1:0];
                CFG_COUNTER_COUNT:      count_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        order_eff  = (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
        offset     = OFFSET_BITS'(position) << order_eff;
        word_index = offset >> WORD_BITS_LOG2;

        push_job.action     = action_t'(action);
        push_job.order      = order_eff;
        push_job.word_index = word_index[MAX_INDEX_BITS-1:0];
        push_job.bit_offset = MAX_BIT_BITS'(offset[WORD_BITS_LOG2-1:0]);
        push_job.oor        = ({1'b0, position} >= count_reg) || (word_index >= STORE_LIMIT);
    end

    assign in_ready = !q_full && !clearing;
    assign push     = in_valid && in_ready;

endmodule

// File: design/psc_queue.sv
// psc_queue: two-entry queue of classified requests between front and back
// depends on psc_pkg
`timescale 1ns / 1ps

module psc_queue
    import psc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output job_t head
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = slot_reg[rd_ptr_reg];

endmodule

// File: design/psc_back.sv
// psc_back: counter memory, clearing pass and read-modify-write of one counter
// depends on psc_pkg; drains psc_queue and drives the result register
`timescale 1ns / 1ps

module psc_back
    import psc_pkg::*;
#(
    parameter int WORD_BITS_LOG2 = 6,
    parameter int STORE_WORDS    = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_not_empty,
    input  job_t                  q_head,
    output logic                  pop,
    output logic                  clearing,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] counter_value,
    output logic                  out_of_range
);

    localparam int WORD_BITS = 1 << WORD_BITS_LOG2;
    localparam int AW        = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);

    logic [WORD_BITS-1:0] mem [STORE_WORDS];

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [AW-1:0]        clr_addr_reg;
    job_t                 job_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic                 out_oor_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic                  clr_last;
    logic [AW-1:0]         rd_addr;
    logic [VALUE_BITS-1:0] mask;
    logic [VALUE_BITS-1:0] val_old;
    logic [VALUE_BITS-1:0] val_new;
    logic [63:0]           shifted;
    logic [63:0]           field_mask;
    logic [63:0]           merged;

    assign clr_last = clr_addr_reg == LAST_ADDR;
    assign rd_addr  = q_head.word_index[AW-1:0];

    // counter update on the word read in the previous cycle
    always_comb
    begin
        mask       = counter_mask(job_reg.order);
        shifted    = 64'(rd_data_reg) >> job_reg.bit_offset;
        val_old    = shifted[VALUE_BITS-1:0] & mask;
        case (job_reg.action)
            ACT_SET: val_new = val_old | VALUE_BITS'(1);
            ACT_ADD: val_new = (val_old != mask) ? val_old + VALUE_BITS'(1) : val_old;
            ACT_SUB: val_new = (val_old != '0) ? val_old - VALUE_BITS'(1) : val_old;
            default: val_new = val_old;
        endcase
        field_mask = 64'(mask) << job_reg.bit_offset;
        merged     = (64'(rd_data_reg) & ~field_mask) | (64'(val_new) << job_reg.bit_offset);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_not_empty && (!out_valid_reg || out_ready))
                    state_next = ST_MODIFY;
            end
            ST_MODIFY:
                state_next = ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        case (state_reg)
            ST_CLEAR:
                mem_we = 1'b1;
            ST_IDLE:
                pop = q_not_empty && (!out_valid_reg || out_ready);
            ST_MODIFY:
            begin
                mem_we    = !job_reg.oor && (job_reg.action != ACT_GET);
                mem_waddr = job_reg.word_index[AW-1:0];
                mem_wdata = merged[WORD_BITS-1:0];
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            if (state_reg == ST_MODIFY)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (pop)
        begin
            rd_data_reg <= mem[rd_addr];
            job_reg     <= q_head;
        end
        if (state_reg == ST_MODIFY)
        begin
            out_value_reg <= job_reg.oor ? '0 : val_new;
            out_oor_reg   <= job_reg.oor;
        end
    end

    assign clearing      = state_reg == ST_CLEAR;
    assign out_valid     = out_valid_reg;
    assign counter_value = out_value_reg;
    assign out_of_range  = out_oor_reg;

    // nothing leaves the queue while the store is still being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !pop)
        else $error("request taken during clearing pass");

    // a result appears only right after a modify cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_MODIFY))
        else $error("result raised without a modify cycle");

    // a rejected request never writes the store
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODIFY && job_reg.oor) |-> !mem_we)
        else $error("out-of-range request wrote memory");

    // a flagged result carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_oor_reg) |-> (out_value_reg == '0))
        else $error("out-of-range result with nonzero value");

    // a pending result is never overwritten before its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODIFY) |-> !out_valid_reg)
        else $error("result register overwritten");

endmodule

// File: design/packed_saturating_counter_store.sv
// packed_saturating_counter_store: top level of the packed counter store
// depends on psc_pkg, psc_front, psc_queue and psc_back
`timescale 1ns / 1ps

// Usage
//   requests (action, position) come in on in_valid/in_ready; each one gives
//   exactly one result (counter_value, out_of_range) on out_valid/out_ready.
//   cfg_write with cfg_index/cfg_data sets the counter width (index 0) and the
//   number of counters in use (index 1); write only while the block is idle.
//   a transferred request waits in the queue, is popped into the job and read
//   data registers, and its result is registered in the output register.
//   a request is popped only after the previous one is written back, since the
//   single memory port does a registered read and then a write-back of the same word.
//   reset: the counter memory is cleared by a pass over all STORE_WORDS words,
//   one word a cycle; in_ready stays low until it ends. config registers reset at once.
//   stall: a result waits in the output register while out_ready is low; the
//   two-entry queue keeps taking requests until it fills, then in_ready drops.
//   counters are read and written in place; results keep request order.
module packed_saturating_counter_store
    import psc_pkg::*;
#(
    parameter int WORD_BITS_LOG2 = 6,
    parameter int STORE_WORDS    = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                action,
    input  logic [15:0]               position,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [VALUE_BITS-1:0]     counter_value,
    output logic                      out_of_range
);

    logic push;
    job_t push_job;
    logic pop;
    logic q_full;
    logic q_not_empty;
    job_t q_head;
    logic clearing;

    psc_front #(
        .WORD_BITS_LOG2 (WORD_BITS_LOG2),
        .STORE_WORDS    (STORE_WORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .position  (position),
        .q_full    (q_full),
        .clearing  (clearing),
        .push      (push),
        .push_job  (push_job)
    );

    psc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    psc_back #(
        .WORD_BITS_LOG2 (WORD_BITS_LOG2),
        .STORE_WORDS    (STORE_WORDS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .pop           (pop),
        .clearing      (clearing),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .counter_value (counter_value),
        .out_of_range  (out_of_range)
    );

endmodule

// File: bench/packed_saturating_counter_store_test.sv
// packed_saturating_counter_store_test: self-checking bench for the packed counter store
// depends on psc_pkg and packed_saturating_counter_store; needs no files or arguments
`timescale 1ns / 1ps

import psc_pkg::*;

typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic                  flag;
} counter_result_t;

// shadow copy of the counter words and registers, plus the results still owed
class counter_store_tracker #(parameter int WORD_LOG2 = 6, parameter int WORDS = 1024);
    logic [(1 << WORD_LOG2) - 1:0] words [WORDS];
    logic [2:0]                    width_log2;
    logic [16:0]                   count_limit;
    counter_result_t               pending_results [$];
    int                            failures;

    function new();
        foreach (words[i])
            words[i] = '0;
        width_log2  = 3'd0;
        count_limit = 17'd65536;
        failures    = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        if (idx == CFG_COUNTER_WIDTH_LOG2)
            width_log2 = data[2:0];
        else if (idx == CFG_COUNTER_COUNT)
            count_limit = data[16:0];
    endfunction

    function int outstanding();
        return pending_results.size();
    endfunction

    // work out the counter value after the action and update the shadow words
    function void note_request(action_t act, logic [15:0] pos);
        int unsigned     order;
        int unsigned     bitpos;
        logic [63:0]     maxv;
        logic [63:0]     offset;
        logic [63:0]     widx;
        logic [63:0]     word;
        logic [63:0]     val;
        counter_result_t res;
        order = width_log2;
        if (order > 5)
            order = 5;
        if (order > WORD_LOG2)
            order = WORD_LOG2;
        maxv   = (64'd1 << (1 << order)) - 64'd1;
        offset = {48'd0, pos} << order;
        widx   = offset >> WORD_LOG2;
        bitpos = int'(offset % (64'd1 << WORD_LOG2));
        if ({1'b0, pos} >= count_limit || widx >= WORDS) begin
            res.value = '0;
            res.flag  = 1'b1;
            pending_results.push_back(res);
            return;
        end
        word = 64'(words[int'(widx)]);
        val  = (word >> bitpos) & maxv;
        case (act)
            ACT_SET: val = val | 64'd1;
            ACT_ADD: if (val < maxv) val = val + 64'd1;
            ACT_SUB: if (val > 64'd0) val = val - 64'd1;
            default: ;
        endcase
        if (act != ACT_GET) begin
            word = word & ~(maxv << bitpos);
            word = word | (val << bitpos);
            words[int'(widx)] = word[(1 << WORD_LOG2) - 1:0];
        end
        res.value = val[VALUE_BITS-1:0];
        res.flag  = 1'b0;
        pending_results.push_back(res);
    endfunction

    function void check_result(logic [VALUE_BITS-1:0] value, logic flag);
        counter_result_t exp_res;
        if (pending_results.size() == 0) begin
            $error("unexpected result: counter_value %0h out_of_range %0b", value, flag);
            failures++;
            return;
        end
        exp_res = pending_results.pop_front();
        if (value !== exp_res.value) begin
            $error("counter_value: expected %0h actual %0h", exp_res.value, value);
            failures++;
        end
        if (flag !== exp_res.flag) begin
            $error("out_of_range: expected %0b actual %0b", exp_res.flag, flag);
            failures++;
        end
    endfunction
endclass

module packed_saturating_counter_store_test;

    localparam int WORD_BITS_LOG2 = 6;
    localparam int STORE_WORDS    = 1024;
    localparam int LONG_HOLD      = 50;
    localparam int DRAIN_CYCLES   = 4;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                action;
    logic [15:0]               position;
    logic                      out_valid;
    logic                      out_ready;
    logic [VALUE_BITS-1:0]     counter_value;
    logic                      out_of_range;

    bit send_gaps;
    bit recv_stalls;
    bit hold_request;

    counter_store_tracker #(WORD_BITS_LOG2, STORE_WORDS) tracker;

    packed_saturating_counter_store #(
        .WORD_BITS_LOG2(WORD_BITS_LOG2),
        .STORE_WORDS   (STORE_WORDS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .position     (position),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .counter_value(counter_value),
        .out_of_range (out_of_range)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #200000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(counter_value, out_of_range);
    end

    // result side: random stalls, plus one long hold-off when asked for
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else if (recv_stalls && $urandom_range(0, 4) == 0)
            begin
                out_ready  = 1'b0;
                stall_left = $urandom_range(0, 7);
            end
            else
                out_ready = 1'b1;
        end
    end

    task automatic send_request(input action_t act, input logic [15:0] pos);
        @(negedge clk);
        in_valid = 1'b1;
        action   = act;
        position = pos;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_request(act, pos);
    endtask

    task automatic idle_input(input int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        action   = 2'($urandom);
        position = 16'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    // stop offering and wait until every result has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        tracker.write_register(idx, data);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic configure(input int order, input int count);
        drain_results();
        set_register(CFG_COUNTER_WIDTH_LOG2, CFG_DATA_BITS'(order));
        set_register(CFG_COUNTER_COUNT, CFG_DATA_BITS'(count));
    endtask

    // mostly positions near the bottom so counters get hit again, some anywhere
    task automatic random_requests(input int n, input int pos_hi);
        action_t     act;
        logic [15:0] pos;
        repeat (n)
        begin
            if (send_gaps && $urandom_range(0, 4) == 0)
                idle_input($urandom_range(1, 8));
            act = action_t'($urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0)
                pos = 16'($urandom);
            else
                pos = 16'($urandom_range(0, pos_hi));
            send_request(act, pos);
        end
    endtask

    initial
    begin
        int i;
        tracker      = new();
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        action       = 2'd0;
        position     = 16'd0;
        send_gaps    = 1'b0;
        recv_stalls  = 1'b0;
        hold_request = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // bit map at reset settings: saturation at both ends, top position
        send_request(ACT_GET, 16'd0);
        send_request(ACT_SET, 16'd0);
        send_request(ACT_ADD, 16'd0);
        send_request(ACT_SUB, 16'd0);
        send_request(ACT_SUB, 16'd0);
        send_request(ACT_ADD, 16'hFFFF);
        send_request(ACT_SET, 16'hFFFF);
        send_request(ACT_GET, 16'hFFFF);

        // widest counters read the old bits in place; past the store is rejected
        configure(5, 65536);
        send_request(ACT_GET, 16'd2047);
        send_request(ACT_SUB, 16'd2047);
        send_request(ACT_ADD, 16'd2047);
        send_request(ACT_SET, 16'd2048);
        send_request(ACT_GET, 16'hFFFF);

        // oversized width falls back to 32 bits
        configure(7, 65536);
        send_request(ACT_ADD, 16'd1);
        send_request(ACT_SET, 16'd3);

        // nothing in use
        configure(0, 0);
        send_request(ACT_GET, 16'd0);
        send_request(ACT_SET, 16'hFFFF);

        configure(0, 1);
        send_request(ACT_ADD, 16'd0);
        send_request(ACT_SUB, 16'd1);

        send_gaps   = 1'b1;
        recv_stalls = 1'b1;

        // fill word 0 so the wide counters later sit at their maximum
        configure(0, 65536);
        for (i = 0; i < 64; i++)
            send_request(ACT_SET, 16'(i));
        random_requests(40, 255);

        configure(5, 65536);
        random_requests(60, 7);

        configure(3, 300);
        random_requests(30, 15);
        drain_results();
        random_requests(30, 400);

        configure(1, 1);
        random_requests(30, 3);

        configure(7, 2048);
        random_requests(40, 2100);

        configure(6, 65535);
        random_requests(40, 2047);

        configure(2, 0);
        random_requests(15, 63);

        // long hold-off on results while requests keep coming back to back
        configure(4, 65536);
        send_gaps    = 1'b0;
        hold_request = 1'b1;
        random_requests(25, 31);
        send_gaps = 1'b1;
        random_requests(35, 31);

        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        configure(0, 65536);
        random_requests(60, 127);

        drain_results();
        if (tracker.failures == 0 && tracker.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: packed_saturating_counter_store.f
design/psc_pkg.sv
design/psc_front.sv
design/psc_queue.sv
design/psc_back.sv
design/packed_saturating_counter_store.sv
bench/packed_saturating_counter_store_test.sv
